@@ sv/tmlr_pkg.sv @@
package tmlr_pkg;

    localparam int XY_W   = 5;
    localparam int GRID_W = 6;
    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(16);

    typedef struct packed {
        logic [XY_W-1:0] start_x;
        logic [XY_W-1:0] start_y;
        logic [XY_W-1:0] end_x;
        logic [XY_W-1:0] end_y;
    } line_cmd_t;

    typedef struct packed {
        logic [XY_W-1:0] pixel_x;
        logic [XY_W-1:0] pixel_y;
        logic            show_below;
        logic            show_center;
        logic            show_above;
        logic            last_of_line;
    } pixel_grp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit_start;
        logic emit_step;
        logic emit_end;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
    } dp_status_t;

endpackage

@@ sv/tmlr_dp.sv @@
module tmlr_dp
    import tmlr_pkg::*;
#(
    parameter int COORD_BITS = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [GRID_W-1:0] cfg_data,
    input  line_cmd_t         cmd,
    input  dp_cmd_t           ctl,
    output dp_status_t        status,
    output pixel_grp_t        px
);

    localparam int VW = COORD_BITS + 5;
    localparam int CW = (COORD_BITS + 2 > GRID_W + 1) ? COORD_BITS + 2 : GRID_W + 1;
    localparam int DW = COORD_BITS + 2;

    logic [GRID_W-1:0]            grid_reg;
    logic [COORD_BITS-1:0]        x_reg, x_next;
    logic [COORD_BITS-1:0]        y_reg, y_next;
    logic [COORD_BITS-1:0]        bx_reg, bx_next;
    logic [COORD_BITS-1:0]        by_reg, by_next;
    logic [COORD_BITS-1:0]        dx_reg, dx_next;
    logic signed [COORD_BITS:0]   dy_reg, dy_next;
    logic signed [VW-1:0]         v_reg, v_next;
    logic                         fall_reg, fall_next;
    logic                         steep_reg, steep_next;
    pixel_grp_t                   px_reg, px_next;

    logic [COORD_BITS-1:0]        ax, ay, ex, ey;
    logic signed [DW-1:0]         dy_l, dx_l, mag_l;
    logic signed [VW-1:0]         dx_l_w, dy_l_w, dx_w, dy_w;
    logic [COORD_BITS-1:0]        x_step, y_step;
    logic signed [VW-1:0]         v_step;
    logic                         take;

    function automatic pixel_grp_t make_group(
        input logic [COORD_BITS-1:0] col,
        input logic [COORD_BITS-1:0] row,
        input logic                  below,
        input logic                  above,
        input logic                  last,
        input logic [GRID_W-1:0]     grid
    );
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] g;
        logic signed [CW-1:0] rm;
        logic signed [CW-1:0] rp;
        logic                 col_ok;
        pixel_grp_t           grp;
        c      = $signed(CW'(col));
        r      = $signed(CW'(row));
        g      = $signed(CW'(grid));
        rm     = r - CW'(1);
        rp     = r + CW'(1);
        col_ok = c < g;
        grp.pixel_x      = XY_W'(col);
        grp.pixel_y      = XY_W'(row);
        grp.show_below   = below && col_ok && (rm >= 0) && (rm < g);
        grp.show_center  = col_ok && (r < g);
        grp.show_above   = above && col_ok && (rp < g);
        grp.last_of_line = last;
        return grp;
    endfunction

    // endpoint ordering and per-line setup
    always_comb
    begin
        if (COORD_BITS'(cmd.start_x) > COORD_BITS'(cmd.end_x))
        begin
            ax = COORD_BITS'(cmd.end_x);
            ay = COORD_BITS'(cmd.end_y);
            ex = COORD_BITS'(cmd.start_x);
            ey = COORD_BITS'(cmd.start_y);
        end
        else
        begin
            ax = COORD_BITS'(cmd.start_x);
            ay = COORD_BITS'(cmd.start_y);
            ex = COORD_BITS'(cmd.end_x);
            ey = COORD_BITS'(cmd.end_y);
        end
        dx_l   = $signed(DW'(ex)) - $signed(DW'(ax));
        dy_l   = $signed(DW'(ey)) - $signed(DW'(ay));
        mag_l  = (dy_l < 0) ? -dy_l : dy_l;
        dx_l_w = VW'(dx_l);
        dy_l_w = VW'(dy_l);
    end

    assign dx_w = $signed(VW'(dx_reg));
    assign dy_w = VW'(dy_reg);

    // one walk step of the midpoint rule, decision kept incrementally
    always_comb
    begin
        x_step = x_reg;
        y_step = y_reg;
        v_step = v_reg;
        take   = 1'b0;
        unique case ({fall_reg, steep_reg})
            2'b00:
            begin
                take   = v_reg < 0;
                x_step = x_reg + COORD_BITS'(1);
                y_step = take ? y_reg + COORD_BITS'(1) : y_reg;
                v_step = v_reg - (dy_w <<< 1) + (take ? (dx_w <<< 1) : '0);
            end
            2'b01:
            begin
                take   = v_reg >= 0;
                y_step = y_reg + COORD_BITS'(1);
                x_step = take ? x_reg + COORD_BITS'(1) : x_reg;
                v_step = v_reg + (dx_w <<< 1) - (take ? (dy_w <<< 1) : '0);
            end
            2'b10:
            begin
                take   = v_reg > 0;
                x_step = x_reg + COORD_BITS'(1);
                y_step = take ? y_reg - COORD_BITS'(1) : y_reg;
                v_step = v_reg - (dy_w <<< 1) - (take ? (dx_w <<< 1) : '0);
            end
            default:
            begin
                take   = v_reg <= 0;
                y_step = y_reg - COORD_BITS'(1);
                x_step = take ? x_reg + COORD_BITS'(1) : x_reg;
                v_step = v_reg - (dx_w <<< 1) - (take ? (dy_w <<< 1) : '0);
            end
        endcase
    end

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        v_next     = v_reg;
        fall_next  = fall_reg;
        steep_next = steep_reg;
        px_next    = px_reg;
        if (ctl.load)
        begin
            x_next     = ax;
            y_next     = ay;
            bx_next    = ex;
            by_next    = ey;
            dx_next    = COORD_BITS'(dx_l);
            dy_next    = (COORD_BITS+1)'(dy_l);
            fall_next  = dy_l < 0;
            steep_next = mag_l > dx_l;
            unique case ({dy_l < 0, mag_l > dx_l})
                2'b00:   v_next = dx_l_w - (dy_l_w <<< 1);
                2'b01:   v_next = (dx_l_w <<< 1) - dy_l_w;
                2'b10:   v_next = -dx_l_w - (dy_l_w <<< 1);
                default: v_next = -(dx_l_w <<< 1) - dy_l_w;
            endcase
        end
        else if (ctl.emit_start)
        begin
            px_next = make_group(x_reg, y_reg, 1'b1, 1'b0, 1'b0, grid_reg);
        end
        else if (ctl.emit_step)
        begin
            x_next  = x_step;
            y_next  = y_step;
            v_next  = v_step;
            px_next = make_group(x_step, y_step, 1'b1, 1'b1, 1'b0, grid_reg);
        end
        else if (ctl.emit_end)
        begin
            x_next  = bx_reg;
            y_next  = by_reg;
            px_next = make_group(bx_reg, by_reg, 1'b1, !fall_reg, 1'b1, grid_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= GRID_RESET;
        end
        else if (cfg_we)
        begin
            grid_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            bx_reg    <= '0;
            by_reg    <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            v_reg     <= '0;
            fall_reg  <= 1'b0;
            steep_reg <= 1'b0;
            px_reg    <= '0;
        end
        else
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            bx_reg    <= bx_next;
            by_reg    <= by_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            v_reg     <= v_next;
            fall_reg  <= fall_next;
            steep_reg <= steep_next;
            px_reg    <= px_next;
        end
    end

    assign status.walk_done = steep_reg ? (y_reg == by_reg) : (x_reg == bx_reg);
    assign px               = px_reg;

endmodule

@@ sv/tmlr_ctrl.sv @@
module tmlr_ctrl
    import tmlr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    output logic       px_valid,
    input  logic       px_ready,
    input  dp_status_t status,
    output dp_cmd_t    ctl
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       px_valid_reg, px_valid_next;
    logic       slot_free;
    logic       emit;

    assign slot_free = !px_valid_reg || px_ready;
    assign cmd_ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        ctl.load       = 1'b0;
        ctl.emit_start = 1'b0;
        ctl.emit_step  = 1'b0;
        ctl.emit_end   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (slot_free)
                begin
                    ctl.emit_start = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (slot_free)
                begin
                    if (status.walk_done)
                    begin
                        ctl.emit_end = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        ctl.emit_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign emit = ctl.emit_start || ctl.emit_step || ctl.emit_end;

    always_comb
    begin
        priority if (emit)
            px_valid_next = 1'b1;
        else if (px_ready)
            px_valid_next = 1'b0;
        else
            px_valid_next = px_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            px_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            px_valid_reg <= px_valid_next;
        end
    end

    assign px_valid = px_valid_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (px_valid_reg && !px_ready) |-> !emit)
        else $error("result overwritten while stalled");

    a_load_to_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (state_reg == ST_START))
        else $error("load not followed by start");

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit_end |=> (state_reg == ST_IDLE && px_valid_reg && px_valid == 1'b1))
        else $error("end result not followed by idle");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctl.load, ctl.emit_start, ctl.emit_step, ctl.emit_end}) <= 1)
        else $error("more than one datapath command");

endmodule

@@ sv/thick_midpoint_line_raster_core.sv @@
// a command transaction loads the walk registers; the first result is registered from
//   ST_START once the output slot is free, then one result per cycle while px_ready is
//   high; cmd_ready stays low until the last result of the line is registered
// reset: rst_n is asynchronous, active low; controller returns to idle, no result pending,
//   walk registers clear, grid_size returns to 16
module thick_midpoint_line_raster_core
    import tmlr_pkg::*;
#(
    parameter int COORD_BITS = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [GRID_W-1:0] cfg_data,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  line_cmd_t         cmd,
    output logic              px_valid,
    input  logic              px_ready,
    output pixel_grp_t        px
);

    dp_cmd_t    ctl;
    dp_status_t status;

    tmlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .px_valid  (px_valid),
        .px_ready  (px_ready),
        .status    (status),
        .ctl       (ctl)
    );

    tmlr_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .ctl      (ctl),
        .status   (status),
        .px       (px)
    );

endmodule

@@ tb/line_raster_checker.sv @@
`timescale 1ns / 100ps

module line_raster_checker
    import tmlr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [GRID_W-1:0] cfg_data,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  line_cmd_t         cmd,
    input  logic              px_valid,
    input  logic              px_ready,
    input  pixel_grp_t        px,
    output int                fail_count,
    output int                groups_owed
);

    int         grid_side = int'(GRID_RESET);
    pixel_grp_t owed_groups[$];

    function automatic bit on_grid(int col, int row);
        return col >= 0 && row >= 0 && col < grid_side && row < grid_side;
    endfunction

    function automatic void add_group(int x, int y, bit below, bit above, bit is_end);
        pixel_grp_t g;
        g.pixel_x      = x[XY_W-1:0];
        g.pixel_y      = y[XY_W-1:0];
        g.show_below   = below && on_grid(x, y - 1);
        g.show_center  = on_grid(x, y);
        g.show_above   = above && on_grid(x, y + 1);
        g.last_of_line = is_end;
        owed_groups.push_back(g);
    endfunction

    // midpoint walk, endpoints ordered so x never decreases
    function automatic void raster_line(line_cmd_t c);
        int ax;
        int ay;
        int bx;
        int by;
        int dx;
        int dy;
        int k;
        int x;
        int y;
        int v;
        ax = int'(c.start_x);
        ay = int'(c.start_y);
        bx = int'(c.end_x);
        by = int'(c.end_y);
        if (ax > bx)
        begin
            x  = ax;
            ax = bx;
            bx = x;
            y  = ay;
            ay = by;
            by = y;
        end
        dx = bx - ax;
        dy = by - ay;
        k  = dx * ay - dy * ax;
        x  = ax;
        y  = ay;
        add_group(x, y, 1'b1, 1'b0, 1'b0);
        if (dy >= 0)
        begin
            if (dy <= dx)
            begin
                while (x < bx)
                begin
                    v = dx * (2 * y + 1) - dy * (2 * x + 2) - 2 * k;
                    x++;
                    if (v < 0)
                        y++;
                    add_group(x, y, 1'b1, 1'b1, 1'b0);
                end
            end
            else
            begin
                while (y < by)
                begin
                    v = dx * (2 * y + 2) - dy * (2 * x + 1) - 2 * k;
                    y++;
                    if (v >= 0)
                        x++;
                    add_group(x, y, 1'b1, 1'b1, 1'b0);
                end
            end
            add_group(bx, by, 1'b1, 1'b1, 1'b1);
        end
        else
        begin
            if (-dy <= dx)
            begin
                while (x < bx)
                begin
                    v = dx * (2 * y - 1) - dy * (2 * x + 2) - 2 * k;
                    x++;
                    if (v > 0)
                        y--;
                    add_group(x, y, 1'b1, 1'b1, 1'b0);
                end
            end
            else
            begin
                // falling steep: x steps on a tie
                while (y > by)
                begin
                    v = dx * (2 * y - 2) - dy * (2 * x + 1) - 2 * k;
                    y--;
                    if (v <= 0)
                        x++;
                    add_group(x, y, 1'b1, 1'b1, 1'b0);
                end
            end
            add_group(bx, by, 1'b1, 1'b0, 1'b1);
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(string name, logic [XY_W-1:0] got, logic [XY_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_group(pixel_grp_t got);
        pixel_grp_t want;
        if (owed_groups.size() == 0)
        begin
            report_mismatch($sformatf("pixel transaction with none expected, x %0d y %0d",
                                      got.pixel_x, got.pixel_y));
            return;
        end
        want = owed_groups.pop_front();
        compare_field("pixel_x", got.pixel_x, want.pixel_x);
        compare_field("pixel_y", got.pixel_y, want.pixel_y);
        compare_field("show_below", XY_W'(got.show_below), XY_W'(want.show_below));
        compare_field("show_center", XY_W'(got.show_center), XY_W'(want.show_center));
        compare_field("show_above", XY_W'(got.show_above), XY_W'(want.show_above));
        compare_field("last_of_line", XY_W'(got.last_of_line), XY_W'(want.last_of_line));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side = int'(GRID_RESET);
            owed_groups.delete();
        end
        else
        begin
            if (cfg_we)
                grid_side = int'(cfg_data);
            if (px_valid && px_ready)
                check_group(px);
            if (cmd_valid && cmd_ready)
                raster_line(cmd);
        end
        groups_owed = owed_groups.size();
    end

endmodule

@@ tb/thick_midpoint_line_raster_core_tb.sv @@
`timescale 1ns / 100ps

module thick_midpoint_line_raster_core_tb;
    import tmlr_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int LINES_PER_RUN = 43;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [GRID_W-1:0] cfg_data  = '0;
    logic              cmd_valid = 1'b0;
    line_cmd_t         cmd       = '0;
    logic              px_ready  = 1'b0;
    logic              cmd_ready;
    logic              px_valid;
    pixel_grp_t        px;

    int fail_count;
    int groups_owed;
    int send_idle_pct = 14;
    int recv_idle_pct = 55;
    int quiet_cycles  = 0;

    always #1 clk = ~clk;

    thick_midpoint_line_raster_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .px_valid  (px_valid),
        .px_ready  (px_ready),
        .px        (px)
    );

    line_raster_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .px_valid    (px_valid),
        .px_ready    (px_ready),
        .px          (px),
        .fail_count  (fail_count),
        .groups_owed (groups_owed)
    );

    always @(posedge clk)
        px_ready <= ($urandom_range(99) >= recv_idle_pct);

    // no transaction on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (px_valid && px_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("thick_midpoint_line_raster_core: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic line_cmd_t make_line(int ax, int ay, int bx, int by);
        line_cmd_t c;
        c.start_x = ax[XY_W-1:0];
        c.start_y = ay[XY_W-1:0];
        c.end_x   = bx[XY_W-1:0];
        c.end_y   = by[XY_W-1:0];
        return c;
    endfunction

    // a quarter of the coordinates sit at the grid edges
    function automatic int pick_coord();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 31 - $urandom_range(1) : $urandom_range(1);
        return $urandom_range(31);
    endfunction

    function automatic line_cmd_t random_line();
        int ax;
        int ay;
        int bx;
        int by;
        ax = pick_coord();
        ay = pick_coord();
        bx = pick_coord();
        by = pick_coord();
        return make_line(ax, ay, bx, by);
    endfunction

    task automatic send_line(line_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic drain_lines();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (groups_owed != 0);
        @(posedge clk);
    endtask

    task automatic set_grid(logic [GRID_W-1:0] side);
        cfg_we   <= 1'b1;
        cfg_data <= side;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        logic [GRID_W-1:0] side;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners, flat and vertical lines, every slope case, swapped endpoints
        send_line(make_line(0, 0, 0, 0));
        send_line(make_line(31, 31, 31, 31));
        send_line(make_line(0, 0, 31, 31));
        send_line(make_line(31, 31, 0, 0));
        send_line(make_line(0, 31, 31, 0));
        send_line(make_line(31, 0, 0, 31));
        send_line(make_line(0, 0, 31, 0));
        send_line(make_line(31, 31, 0, 31));
        send_line(make_line(5, 0, 5, 31));
        send_line(make_line(5, 31, 5, 0));
        send_line(make_line(0, 0, 31, 10));
        send_line(make_line(0, 0, 10, 31));
        send_line(make_line(0, 31, 31, 20));
        send_line(make_line(0, 31, 10, 0));
        send_line(make_line(2, 10, 5, 2));
        send_line(make_line(9, 2, 3, 7));
        send_line(make_line(10, 20, 4, 15));
        send_line(make_line(15, 16, 16, 15));
        send_line(make_line(16, 15, 15, 16));
        send_line(make_line(0, 1, 31, 0));
        send_line(make_line(30, 31, 31, 0));
        send_line(make_line(14, 15, 17, 16));
        drain_lines();

        for (int run = 0; run < 6; run++)
        begin
            case (run / 2)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 55;
                end
                1:
                begin
                    send_idle_pct = 55;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (run)
                0:       side = 6'd32;
                1:       side = 6'd1;
                2:       side = 6'd0;
                3:       side = 6'd63;
                4:       side = 6'd33;
                default: side = GRID_W'($urandom_range(31, 2));
            endcase
            set_grid(side);
            repeat (LINES_PER_RUN)
                send_line(random_line());
            drain_lines();
        end

        repeat (8)
            @(posedge clk);
        if (fail_count == 0 && groups_owed == 0)
            $display("thick_midpoint_line_raster_core: match");
        else
            $display("thick_midpoint_line_raster_core: mismatch");
        $finish;
    end

endmodule
